// ===== rtl/core/dsrc_pkg.sv =====
package dsrc_pkg;

  localparam int MAX_DIGITS_DEF = 16;
  localparam int VAL_W = 54;
  localparam int SUM_W = 8;

  typedef struct packed {
    logic [VAL_W-1:0] range_low;
    logic [VAL_W-1:0] range_high;
    logic [SUM_W-1:0] target_sum;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] match_count;
    logic [VAL_W-1:0] first_match_res;
    logic             found;
  } out_word_t;

endpackage

// ===== rtl/core/digit_sum_range_counter.sv =====
// channel | dir | handshake          | payload
// in      | in  | in_valid/in_ready  | dsrc_pkg::in_word_t
// out     | out | out_valid/out_ready| dsrc_pkg::out_word_t
// After reset the ways table is built in RAM, one read per cycle, with a
// write per entry once its reads land; no word is taken meanwhile.
// One word at a time: a digit split and a digit walk, once for lo and once
// for hi, then a search for the raised position and a digit-by-digit build
// of the value, most significant digit first.
// Empty ranges and unreachable sums go straight from the check to the result.
// A stalled result holds the block; the next word waits for it.
module digit_sum_range_counter #(
  parameter int MAX_DIGITS = dsrc_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsrc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dsrc_pkg::out_word_t out_word
);

  dsrc_core #(.MAX_DIGITS(MAX_DIGITS)) u_core (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

endmodule

// ===== rtl/core/dsrc_ram.sv =====
module dsrc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/dsrc_core.sv =====
// Sequencer. After reset it builds the ways table into memory:
// ways[r][t] = sum over c in 0..9 of ways[r-1][t-c], one read per cycle.
// Per word it splits lo into digits (shift and add-3, one bit a cycle),
// counts up to lo, splits hi and counts up to hi, one table read per
// candidate digit. count(lo - 1) is count(lo) less the hit on lo itself.
// The smallest match is lo when lo hits, else lo's prefix up to the deepest
// position that can be raised, then the smallest suffix with the rest sum.
module dsrc_core #(
  parameter int MAX_DIGITS = dsrc_pkg::MAX_DIGITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dsrc_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dsrc_pkg::out_word_t out_word
);

  localparam int SUM_CAP = 9 * MAX_DIGITS;
  localparam int NT = SUM_CAP + 1;
  localparam int RW = $clog2(MAX_DIGITS + 1);
  localparam int TW = $clog2(NT);
  localparam int DEPTH = (MAX_DIGITS + 1) * NT;
  localparam int AW = $clog2(DEPTH);
  localparam int VW = dsrc_pkg::VAL_W;
  localparam int SW = dsrc_pkg::SUM_W;
  localparam int DW = 4 * MAX_DIGITS;
  localparam int PW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int CW = $clog2(VW);
  localparam int XW = SW + 3;

  function automatic logic [63:0] pow10m1();
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < MAX_DIGITS; i++) p = p * 64'd10;
    return p - 64'd1;
  endfunction

  localparam logic [63:0] TOP = pow10m1();

  function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [TW-1:0] t);
    return AW'(AW'(r) * AW'(NT) + AW'(t));
  endfunction

  typedef enum logic [3:0] {
    S_INIT0, S_INIT, S_IDLE, S_CHK, S_CONV, S_WALK, S_SRCH, S_ASM, S_DONE
  } state_t;

  state_t state;

  // table memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [VW-1:0] wdata, rdata;

  dsrc_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_ways (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // table build
  logic [RW-1:0] ir;
  logic [TW-1:0] it;
  logic [3:0]    ic;
  logic          pend;
  logic [VW-1:0] acc;

  // query registers
  logic [VW-1:0] lo, hi;
  logic [SW-1:0] tgt;
  logic          phase;       // 0: count up to lo, 1: count up to hi
  logic [VW-1:0] sh;
  logic [DW-1:0] bcd, ldig;
  logic [CW-1:0] step;
  logic [PW-1:0] pos;
  logic [3:0]    cd;
  logic [XW-1:0] prefix;
  logic [VW-1:0] total, base, cnt_r;
  // smallest match
  logic [XW-1:0] psum;
  logic [PW-1:0] bk;
  logic [3:0]    bd;
  logic [XW-1:0] rem;
  logic          lo_hit;
  logic [VW-1:0] xval;

  // table build controls
  logic [3:0]    init_lim;
  logic          init_issue;
  logic [VW-1:0] init_sum;
  assign init_lim = (it < TW'(9)) ? 4'(it) : 4'd9;
  assign init_issue = (state == S_INIT) && (ic <= init_lim);
  assign init_sum = acc + (pend ? rdata : '0);

  // binary to digits: add 3 to each digit of 5 or more, then shift
  logic [DW-1:0] bcd_adj, bcd_sh;
  always_comb begin
    for (int i = 0; i < MAX_DIGITS; i++)
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
  end
  assign bcd_sh = {bcd_adj[DW-2:0], sh[VW-1]};

  // digit walk
  logic [3:0]           cur_d;
  logic signed [XW-1:0] need_w;
  logic                 walk_issue;
  logic [VW-1:0]        walk_sum, walk_fin;
  logic [XW-1:0]        new_pre;
  logic                 last_pos, walk_hit;
  assign cur_d = bcd[DW-1-4*pos -: 4];
  assign need_w = XW'(tgt) - prefix - XW'(cd);
  assign walk_issue = (state == S_WALK) && (cd < cur_d) && !need_w[XW-1];
  assign walk_sum = total + (pend ? rdata : '0);
  assign new_pre = prefix + XW'(cur_d);
  assign last_pos = (pos == PW'(MAX_DIGITS - 1));
  assign walk_hit = last_pos && (new_pre == XW'(tgt));
  assign walk_fin = walk_sum + VW'(walk_hit);

  // deepest raisable position and the least digit there
  logic [3:0]           lo_d;
  logic [XW-1:0]        rest_x, nine_rest;
  logic signed [XW-1:0] avail_s, lower_s, lod1_s, dmin_s, fill_s;
  logic                 feas;
  logic [3:0]           asm_d;
  logic [VW-1:0]        xval_next;
  assign lo_d = ldig[DW-1-4*pos -: 4];
  assign rest_x = XW'(MAX_DIGITS - 1) - XW'(pos);
  assign nine_rest = rest_x * XW'(9);

  always_comb begin
    avail_s = XW'(tgt) - psum;
    lower_s = avail_s - nine_rest;
    lod1_s = XW'(lo_d) + XW'(1);
    dmin_s = (lower_s > lod1_s) ? lower_s : lod1_s;
    feas = (lo_d != 4'd9) && (dmin_s <= $signed(XW'(9))) && (dmin_s <= avail_s);
    fill_s = rem - nine_rest;
  end

  // result digit: lo prefix, raised digit, then smallest suffix
  always_comb begin
    if (pos < bk) asm_d = lo_d;
    else if (pos == bk) asm_d = bd;
    else if (fill_s[XW-1]) asm_d = 4'd0;
    else asm_d = fill_s[3:0];
  end
  assign xval_next = {xval[VW-4:0], 3'b000} + {xval[VW-2:0], 1'b0} + VW'(asm_d);

  // memory ports
  assign we = (state == S_INIT0) || (state == S_INIT && !init_issue);
  assign waddr = addr_of(ir, it);
  assign wdata = (state == S_INIT0) ? VW'(it == '0) : init_sum;
  assign raddr = init_issue ? addr_of(ir - RW'(1), it - TW'(ic)) :
                 walk_issue ? addr_of(RW'(MAX_DIGITS - 1) - RW'(pos), TW'(need_w)) :
                 '0;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT0;
      ir <= '0;
      it <= '0;
      ic <= 4'd0;
      acc <= '0;
      pend <= 1'b0;
      out_word <= '0;
    end else begin
      case (state)
        // row zero: only the empty string with sum zero
        S_INIT0: begin
          if (it == TW'(SUM_CAP)) begin
            it <= '0;
            ir <= RW'(1);
            ic <= 4'd0;
            acc <= '0;
            pend <= 1'b0;
            state <= S_INIT;
          end else begin
            it <= it + TW'(1);
          end
        end
        // other rows: one read per cycle, write when the last read lands
        S_INIT: begin
          pend <= init_issue;
          if (init_issue) begin
            ic <= ic + 4'd1;
            acc <= init_sum;
          end else begin
            ic <= 4'd0;
            acc <= '0;
            if (it == TW'(SUM_CAP)) begin
              it <= '0;
              if (ir == RW'(MAX_DIGITS)) state <= S_IDLE;
              else ir <= ir + RW'(1);
            end else begin
              it <= it + TW'(1);
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            lo <= (64'(in_word.range_low) > TOP) ? VW'(TOP) : in_word.range_low;
            hi <= (64'(in_word.range_high) > TOP) ? VW'(TOP) : in_word.range_high;
            tgt <= in_word.target_sum;
            state <= S_CHK;
          end
        end
        // empty range or unreachable sum ends at once
        S_CHK: begin
          if (lo > hi || tgt > SW'(SUM_CAP)) begin
            out_word <= '0;
            state <= S_DONE;
          end else begin
            sh <= lo;
            bcd <= '0;
            step <= '0;
            phase <= 1'b0;
            state <= S_CONV;
          end
        end
        // split the bound into digits, one bit a cycle
        S_CONV: begin
          bcd <= bcd_sh;
          sh <= {sh[VW-2:0], 1'b0};
          if (step == CW'(VW - 1)) begin
            step <= '0;
            if (!phase) ldig <= bcd_sh;
            pos <= '0;
            cd <= 4'd0;
            prefix <= '0;
            total <= '0;
            pend <= 1'b0;
            state <= S_WALK;
          end else begin
            step <= step + CW'(1);
          end
        end
        // digit walk: one read per candidate below the bound digit
        S_WALK: begin
          pend <= walk_issue;
          if (cd < cur_d) begin
            cd <= cd + 4'd1;
            total <= walk_sum;
          end else if (new_pre > XW'(tgt) || last_pos) begin
            if (!phase) begin
              base <= walk_sum;
              phase <= 1'b1;
              sh <= hi;
              bcd <= '0;
              step <= '0;
              state <= S_CONV;
            end else begin
              cnt_r <= walk_fin - base;
              if (walk_fin == base) begin
                out_word <= '0;
                state <= S_DONE;
              end else begin
                pos <= '0;
                psum <= '0;
                bk <= '0;
                bd <= 4'd0;
                rem <= '0;
                state <= S_SRCH;
              end
            end
          end else begin
            prefix <= new_pre;
            pos <= pos + PW'(1);
            cd <= 4'd0;
            total <= walk_sum;
          end
        end
        // keep the deepest position that can be raised
        S_SRCH: begin
          psum <= psum + XW'(lo_d);
          if (feas) begin
            bk <= pos;
            bd <= dmin_s[3:0];
            rem <= XW'(avail_s - dmin_s);
          end
          if (last_pos) begin
            lo_hit <= (psum + XW'(lo_d) == XW'(tgt));
            pos <= '0;
            xval <= '0;
            state <= S_ASM;
          end else begin
            pos <= pos + PW'(1);
          end
        end
        // build the value, most significant digit first
        S_ASM: begin
          if (lo_hit) begin
            out_word <= '{match_count: cnt_r, first_match_res: lo, found: 1'b1};
            state <= S_DONE;
          end else begin
            xval <= xval_next;
            if (pos > bk) rem <= rem - XW'(asm_d);
            if (last_pos) begin
              out_word <= '{match_count: cnt_r, first_match_res: xval_next, found: 1'b1};
              state <= S_DONE;
            end else begin
              pos <= pos + PW'(1);
            end
          end
        end
        S_DONE: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_INIT0;
      endcase
    end
  end

endmodule

// ===== rtl/core/dsrc_check.sv =====
module dsrc_check (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input dsrc_pkg::out_word_t out_word
);

  // one word in flight: no input taken while a result waits
  a_excl: assert property (@(posedge clk) disable iff (rst) !(in_ready && out_valid))
    else $error("input ready while result pending");

  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_word))
    else $error("result changed under stall");

  // no match means zero fields
  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_word.found |-> out_word.match_count == '0
      && out_word.first_match_res == '0)
    else $error("nonzero fields without match");

  // a result follows an accepted word, never at once
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !out_valid)
    else $error("result too early");

endmodule

bind digit_sum_range_counter dsrc_check u_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
);

// ===== tb/tb_top.sv =====
module tb_top;

  localparam int NDIG = dsrc_pkg::MAX_DIGITS_DEF;
  localparam int SUM_CAP = 9 * NDIG;
  localparam int VW = dsrc_pkg::VAL_W;
  localparam int SW = dsrc_pkg::SUM_W;
  localparam longint unsigned TOP_VAL = 64'd9999999999999999;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  dsrc_pkg::in_word_t in_word;
  logic out_valid;
  logic out_ready;
  dsrc_pkg::out_word_t out_word;

  digit_sum_range_counter i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_word(in_word),
    .out_valid(out_valid), .out_ready(out_ready), .out_word(out_word)
  );

  // ways_tbl[r][t]: r-digit strings with leading zeros whose digits sum to t
  longint unsigned ways_tbl [0:NDIG][0:SUM_CAP];

  dsrc_pkg::in_word_t query_q[$];
  dsrc_pkg::out_word_t answer_q[$];
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_send;
  int err_cnt;
  int sent_cnt;
  int got_cnt;
  int hit_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("Timeout with %0d answers pending", answer_q.size());
    $display("== FAIL ==");
    $finish;
  end

  // count of x in [0, bound] with digit sum equal to tgt
  function automatic longint unsigned sum_hits_upto(longint unsigned bound, int tgt);
    int digs [NDIG];
    int pre;
    int need;
    longint unsigned tot;
    longint unsigned v;
    pre = 0;
    tot = 0;
    v = bound;
    for (int i = NDIG - 1; i >= 0; i--) begin
      digs[i] = int'(v % 10);
      v = v / 10;
    end
    for (int i = 0; i < NDIG; i++) begin
      for (int c = 0; c < digs[i]; c++) begin
        need = tgt - pre - c;
        if (need >= 0 && need <= SUM_CAP) tot += ways_tbl[NDIG - 1 - i][need];
      end
      pre += digs[i];
      if (pre > tgt) return tot;
    end
    if (pre == tgt) tot += 1;
    return tot;
  endfunction

  function automatic dsrc_pkg::out_word_t range_answer(dsrc_pkg::in_word_t q);
    dsrc_pkg::out_word_t r;
    longint unsigned lo, hi, base, cnt, lft, rgt, mid;
    int tgt;
    r = '0;
    lo = 64'(q.range_low);
    hi = 64'(q.range_high);
    tgt = int'(q.target_sum);
    if (lo > TOP_VAL) lo = TOP_VAL;
    if (hi > TOP_VAL) hi = TOP_VAL;
    if (lo <= hi && tgt <= SUM_CAP) begin
      base = (lo == 0) ? 0 : sum_hits_upto(lo - 1, tgt);
      cnt = sum_hits_upto(hi, tgt) - base;
      r.match_count = cnt[VW-1:0];
      if (cnt > 0) begin
        lft = lo;
        rgt = hi;
        while (lft < rgt) begin
          mid = lft + (rgt - lft) / 2;
          if (sum_hits_upto(mid, tgt) > base) rgt = mid;
          else lft = mid + 1;
        end
        r.first_match_res = lft[VW-1:0];
        r.found = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp);
    $display("Mismatch on answer %0d: %s got %0d expected %0d", got_cnt, what, got, exp);
    err_cnt++;
  endtask

  function automatic longint unsigned rand_val();
    longint unsigned v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 2000);
      1: v = {$urandom, $urandom} % (TOP_VAL + 1);
      2: v = TOP_VAL - $urandom_range(0, 1000);
      3: v = {$urandom, $urandom} & ((64'd1 << VW) - 1);
      4: v = {$urandom, $urandom} % 64'd100000000;
      default: v = {$urandom, $urandom} % 64'd10000000000;
    endcase
    return v;
  endfunction

  function automatic dsrc_pkg::in_word_t mk_query(longint unsigned lo, longint unsigned hi,
                                                  int s);
    dsrc_pkg::in_word_t q;
    q.range_low = lo[VW-1:0];
    q.range_high = hi[VW-1:0];
    q.target_sum = s[SW-1:0];
    return q;
  endfunction

  // driver: next word from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (query_q.size() > 0 && !hold_send && $urandom_range(0, 99) >= send_idle_pct) begin
        in_word <= query_q[0];
        answer_q.insert(answer_q.size(), range_answer(query_q[0]));
        query_q.pop_front();
        in_valid <= 1'b1;
        sent_cnt++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: compare each taken word with the oldest expected answer
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        got_cnt++;
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected word, found", out_word.found, 0);
        end else begin
          if (out_word.match_count != answer_q[0].match_count)
            report_mismatch("match_count", out_word.match_count, answer_q[0].match_count);
          if (out_word.first_match_res != answer_q[0].first_match_res)
            report_mismatch("first_match_res", out_word.first_match_res,
                            answer_q[0].first_match_res);
          if (out_word.found != answer_q[0].found)
            report_mismatch("found", out_word.found, answer_q[0].found);
          if (answer_q[0].found) hit_cnt++;
          answer_q.pop_front();
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  initial begin
    longint unsigned lo, hi;
    int s;
    for (int r = 0; r <= NDIG; r++)
      for (int t = 0; t <= SUM_CAP; t++) begin
        ways_tbl[r][t] = (r == 0 && t == 0) ? 1 : 0;
        if (r > 0)
          for (int c = 0; c <= 9 && c <= t; c++) ways_tbl[r][t] += ways_tbl[r-1][t-c];
      end
    err_cnt = 0;
    sent_cnt = 0;
    got_cnt = 0;
    hit_cnt = 0;
    hold_send = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 85;
    rst = 1'b1;
    in_valid = 1'b0;
    in_word = '0;
    out_ready = 1'b0;

    // directed: extremes, empty range, zero bound, saturation, unreachable sum
    query_q.insert(query_q.size(), mk_query(1, TOP_VAL, 1));
    query_q.insert(query_q.size(), mk_query(1, TOP_VAL, SUM_CAP));
    query_q.insert(query_q.size(), mk_query(0, 0, 0));
    query_q.insert(query_q.size(), mk_query(0, 100, 0));
    query_q.insert(query_q.size(), mk_query(1, 1, 1));
    query_q.insert(query_q.size(), mk_query(500, 10, 5));
    query_q.insert(query_q.size(), mk_query(TOP_VAL + 5, (64'd1 << VW) - 1, SUM_CAP));
    query_q.insert(query_q.size(), mk_query((64'd1 << VW) - 1, (64'd1 << VW) - 1, 0));
    query_q.insert(query_q.size(), mk_query(1, TOP_VAL, SUM_CAP + 1));
    query_q.insert(query_q.size(), mk_query(1, TOP_VAL, 255));
    query_q.insert(query_q.size(), mk_query(1, 1000, 27));
    query_q.insert(query_q.size(), mk_query(999, 1001, 2));
    query_q.insert(query_q.size(), mk_query(123456789, 987654321, 45));
    query_q.insert(query_q.size(), mk_query(TOP_VAL - 9, TOP_VAL, SUM_CAP - 1));
    query_q.insert(query_q.size(), mk_query(10, 19, 10));
    query_q.insert(query_q.size(), mk_query(0, TOP_VAL, 0));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      if (ph == 1) begin
        send_idle_pct = 85;
        recv_idle_pct = 38;
      end else if (ph == 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int n = 0; n < 180; n++) begin
        lo = rand_val();
        hi = ($urandom_range(0, 9) == 0) ? rand_val() : lo + rand_val() % 64'd1000000;
        if (hi >= (64'd1 << VW)) hi = (64'd1 << VW) - 1;
        case ($urandom_range(0, 7))
          0: s = $urandom_range(0, 255);
          1: s = $urandom_range(0, SUM_CAP);
          default: s = $urandom_range(0, 60);
        endcase
        query_q.insert(query_q.size(), mk_query(lo, hi, s));
      end
      wait (query_q.size() == 0);
      // hold the sender back until every answer has arrived
      hold_send = 1'b1;
      wait (answer_q.size() == 0 && !in_valid);
      @(posedge clk);
      hold_send = 1'b0;
    end

    repeat (1000) begin
      @(posedge clk);
      if (answer_q.size() == 0) break;
    end
    repeat (500) @(posedge clk);
    $display("Sent %0d range queries, %0d answers checked, %0d with a match",
             sent_cnt, got_cnt, hit_cnt);
    $display("Covered saturation, empty ranges, zero bound and unreachable sums");
    if (err_cnt == 0 && answer_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d errors, %0d answers missing", err_cnt, answer_q.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
